// ===== hdl/minimal_standard_prng_31_core_assert.svh =====
// Assertion macros shared by the generator RTL.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef MINIMAL_STANDARD_PRNG_31_CORE_ASSERT_SVH
`define MINIMAL_STANDARD_PRNG_31_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSPR31_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSPR31_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/mspr31_pkg.sv =====
package mspr31_pkg;

  localparam logic [31:0] MODULUS = 32'h7fff_ffff;
  localparam logic [14:0] MULT    = 15'd16807;
  localparam logic [15:0] LO_MASK = 16'hffff;
  localparam logic [14:0] HI_MASK = 15'h7fff;
  localparam int unsigned HI_SHIFT   = 15;
  localparam int unsigned HALF_WIDTH = 16;

  typedef enum logic [1:0] {
    CMD_DRAW31 = 2'd0,
    CMD_DRAW32 = 2'd1,
    CMD_MIX    = 2'd2,
    CMD_SEED   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] data_word;
    logic        first_of_call;
    logic        last_of_call;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] random_value;
    logic [31:0] state_now;
    logic [30:0] initial_seed;
    logic        seed_refused;
  } out_beat_t;

  // Full reduction of a 32-bit word modulo 2^31-1 by folding bit 31 back in.
  function automatic logic [31:0] reduce_mod(input logic [31:0] v);
    logic [31:0] folded;
    folded = {1'b0, v[30:0]} + {31'd0, v[31]};
    if (folded >= MODULUS) begin
      reduce_mod = folded - MODULUS;
    end else begin
      reduce_mod = folded;
    end
  endfunction

endpackage

// ===== hdl/mspr31_mulfold.sv =====
module mspr31_mulfold (
  input  logic [31:0] state_in,
  output logic [31:0] state_out
);
  import mspr31_pkg::*;

  logic [30:0] lo_prod;
  logic [30:0] hi_prod;
  logic [31:0] folded;

  // Each half of the state is multiplied separately; the high product is
  // folded back because 2^31 is congruent to 1.
  assign lo_prod = {16'd0, MULT} * {15'd0, state_in[15:0] & LO_MASK};
  assign hi_prod = {16'd0, MULT} * {15'd0, state_in[31:HALF_WIDTH]};
  assign folded  = {1'b0, lo_prod}
                 + {1'b0, hi_prod[14:0] & HI_MASK, 16'd0}
                 + {16'd0, hi_prod[30:HI_SHIFT]};

  always_comb begin
    if (folded > MODULUS) begin
      state_out = folded - MODULUS;
    end else begin
      state_out = folded;
    end
  end

endmodule

// ===== hdl/minimal_standard_prng_31_core.sv =====
// A load or a plain mix word goes from acceptance straight to the finishing step; a
// draw31 or a first mix word first needs 1 advance and a draw32 needs 3. Items do not
// overlap: a new one is taken only as the last one finishes, and the single
// multiply-and-fold unit does one advance per cycle. Reset (rst, synchronous,
// active high) sets the state, the saved draw and the seed to 1 and empties the output.
`include "minimal_standard_prng_31_core_assert.svh"

module minimal_standard_prng_31_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mspr31_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mspr31_pkg::out_beat_t out_data
);
  import mspr31_pkg::*;

  // The sequencer is idle, stepping the shared advance unit, or finishing
  // the item (mix, seed load and publishing the result beat).
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADV  = 3'b010,
    S_POST = 3'b100
  } seq_state_t;

  seq_state_t  state;
  cmd_t        cmd_q;
  logic [31:0] word_q;
  logic        last_q;
  logic [1:0]  step_q;
  logic [1:0]  last_step_q;
  logic [31:0] gen_state;
  logic [30:0] saved_draw;
  logic [30:0] first_seed;
  logic [31:0] acc;

  logic [31:0] adv_value;
  logic [31:0] addend;
  logic [31:0] mix_value;
  logic [31:0] red_in;
  logic [31:0] red_value;
  logic        seed_zero;
  logic [31:0] gen_final;
  logic [30:0] seed_final;
  logic        in_fire;
  logic        post_fire;

  // The one arithmetic unit: a single modular multiply by 16807 per cycle.
  mspr31_mulfold u_mulfold (
    .state_in  (gen_state),
    .state_out (adv_value)
  );

  // The item finishes when the output register is free or being emptied.
  // A new item may be taken in the same cycle, so the sequencer does not
  // pass through idle between back-to-back items.
  assign post_fire = (state == S_POST) && (!out_valid || !out_stall);
  assign in_stall  = !((state == S_IDLE) || post_fire);
  assign in_fire   = in_valid && !in_stall;

  // A draw32 sums three rotations of the successive states; a draw31 takes
  // the single new state as it is; a first mix word contributes nothing.
  always_comb begin
    addend = '0;
    unique case (cmd_q)
      CMD_DRAW31: addend = adv_value;
      CMD_DRAW32: begin
        unique case (step_q)
          2'd0:    addend = {adv_value[10:0], adv_value[31:11]};
          2'd1:    addend = {adv_value[16:0], adv_value[31:17]};
          default: addend = {adv_value[26:0], adv_value[31:27]};
        endcase
      end
      CMD_MIX:  addend = '0;
      CMD_SEED: addend = '0;
      default:  addend = '0;
    endcase
  end

  // Finishing step. One reducer serves both the closing mix word and the
  // seed load, which never need it at the same time.
  assign mix_value = gen_state ^ word_q;
  assign red_in    = (cmd_q == CMD_SEED) ? word_q : mix_value;
  assign red_value = reduce_mod(red_in);
  assign seed_zero = (red_value == 32'd0);

  always_comb begin
    gen_final  = gen_state;
    seed_final = first_seed;
    unique case (cmd_q)
      CMD_MIX: begin
        if (!last_q) begin
          gen_final = mix_value;
        end else if (seed_zero) begin
          // A closing word that leaves zero falls back to the saved draw.
          gen_final = {1'b0, saved_draw};
        end else begin
          gen_final = red_value;
        end
      end
      CMD_SEED: begin
        // A seed that is zero modulo 2^31-1 is refused and changes nothing.
        if (!seed_zero) begin
          gen_final  = red_value;
          seed_final = red_value[30:0];
        end
      end
      CMD_DRAW31: gen_final = gen_state;
      CMD_DRAW32: gen_final = gen_state;
      default:    gen_final = gen_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      gen_state  <= 32'd1;
      saved_draw <= 31'd1;
      first_seed <= 31'd1;
    end else begin
      if (out_valid && !out_stall && !post_fire) begin
        out_valid <= 1'b0;
      end

      if (state == S_ADV) begin
        gen_state <= adv_value;
        acc       <= acc + addend;
        step_q    <= step_q + 2'd1;
        if (cmd_q == CMD_MIX) begin
          saved_draw <= adv_value[30:0];
        end
        if (step_q == last_step_q) begin
          state <= S_POST;
        end
      end

      if (post_fire) begin
        gen_state             <= gen_final;
        first_seed            <= seed_final;
        out_valid             <= 1'b1;
        out_data.random_value <= acc;
        out_data.state_now    <= gen_final;
        out_data.initial_seed <= seed_final;
        out_data.seed_refused <= (cmd_q == CMD_SEED) && seed_zero;
        if (!in_fire) begin
          state <= S_IDLE;
        end
      end

      if (in_fire) begin
        cmd_q   <= in_data.command;
        word_q  <= in_data.data_word;
        last_q  <= in_data.last_of_call;
        step_q  <= 2'd0;
        acc     <= '0;
        unique case (in_data.command)
          CMD_DRAW31: begin
            last_step_q <= 2'd0;
            state       <= S_ADV;
          end
          CMD_DRAW32: begin
            last_step_q <= 2'd2;
            state       <= S_ADV;
          end
          CMD_MIX: begin
            last_step_q <= 2'd0;
            state       <= in_data.first_of_call ? S_ADV : S_POST;
          end
          CMD_SEED: begin
            last_step_q <= 2'd0;
            state       <= S_POST;
          end
          default: begin
            last_step_q <= 2'd0;
            state       <= S_POST;
          end
        endcase
      end
    end
  end

  // An accepted item always leaves the sequencer busy in the next cycle.
  `MSPR31_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_fire, state != S_IDLE)
  // The advance counter never runs past the number of advances the command needs.
  `MSPR31_ASSERT_NOW(a_step_bound, clk, rst, state == S_ADV, step_q <= last_step_q)
  // A seed load only ever commits a value below the modulus.
  `MSPR31_ASSERT_NOW(a_seed_in_range, clk, rst,
                     (state == S_POST) && (cmd_q == CMD_SEED), red_value < MODULUS)
  // Only the finishing step fills the output register.
  `MSPR31_ASSERT_NEXT(a_out_source, clk, rst, !out_valid && !post_fire, !out_valid)

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

// Checks the minimal standard generator core beat by beat. Every accepted
// input beat is run through a local copy of the generator arithmetic, and each
// result beat is compared field by field with the oldest outstanding
// prediction. A short directed list goes first, covering the seed extremes,
// the refused seeds and the mix corner cases. Random traffic follows in three
// phases of idling. The last phase opens with a long receiver hold-off so
// that the core backs up and stalls its input.
module testbench;
  import mspr31_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 100;

  // One row of the directed list. Where known is set, typed is the result
  // read straight off the arithmetic; otherwise the predictor supplies it.
  typedef struct packed {
    in_beat_t  stim;
    logic      known;
    out_beat_t typed;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Predictor state: the generator word, the draw kept back by the first word
  // of an entropy buffer, and the last seed that was accepted.
  logic [31:0] lcg_state = 32'd1;
  logic [31:0] mix_fallback = 32'd1;
  logic [30:0] loaded_seed = 31'd1;

  out_beat_t awaited_results[$];
  plan_row_t directed_plan[$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_orders = 0;
  int hold_seen = 0;
  int hold_left = 0;

  minimal_standard_prng_31_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // One step of x * 16807 mod (2^31 - 1) by the split-and-fold route. The
  // sums fit in 32 bits and a single subtraction finishes, so a state of
  // 2^31 - 1 or above still comes out below 2^31 and zero stays zero.
  function automatic logic [31:0] lehmer_step(input logic [31:0] s);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = {17'd0, MULT} * {16'd0, s[15:0]};
    hi = {17'd0, MULT} * {16'd0, s[31:16]};
    lo = lo + {1'b0, hi[14:0], 16'd0};
    lo = lo + (hi >> 15);
    if (lo > MODULUS) begin
      lo = lo - MODULUS;
    end
    return lo;
  endfunction

  // Full reduction modulo 2^31 - 1; a 32-bit word needs at most two passes.
  function automatic logic [31:0] fold_mod(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    while (r >= MODULUS) begin
      r = r - MODULUS;
    end
    return r;
  endfunction

  // Works out the result of one accepted beat and moves the predictor on.
  task automatic predict_beat(input in_beat_t b, output out_beat_t r);
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
    logic [31:0] s;
    r = '0;
    case (b.command)
      CMD_DRAW31: begin
        lcg_state = lehmer_step(lcg_state);
        r.random_value = lcg_state;
      end
      CMD_DRAW32: begin
        x1 = lehmer_step(lcg_state);
        x2 = lehmer_step(x1);
        x3 = lehmer_step(x2);
        lcg_state = x3;
        r.random_value = {x1[10:0], x1[31:11]} + {x2[16:0], x2[31:17]}
                       + {x3[26:0], x3[31:27]};
      end
      CMD_MIX: begin
        // The opening draw comes before the XOR, the closing fold after it.
        if (b.first_of_call) begin
          lcg_state = lehmer_step(lcg_state);
          mix_fallback = {1'b0, lcg_state[30:0]};
        end
        lcg_state = lcg_state ^ b.data_word;
        if (b.last_of_call) begin
          lcg_state = fold_mod(lcg_state);
          if (lcg_state == 32'd0) begin
            lcg_state = mix_fallback;
          end
        end
      end
      default: begin
        // A seed that is a multiple of the modulus is refused and nothing moves.
        s = fold_mod(b.data_word);
        if (s == 32'd0) begin
          r.seed_refused = 1'b1;
        end else begin
          lcg_state = s;
          loaded_seed = s[30:0];
        end
      end
    endcase
    r.state_now = lcg_state;
    r.initial_seed = loaded_seed;
  endtask

  task automatic add_row(input cmd_t c, input logic [31:0] d, input logic f,
                         input logic l, input logic known, input logic [31:0] v,
                         input logic [31:0] st, input logic [30:0] sd,
                         input logic rf);
    plan_row_t row;
    row.stim = '{command: c, data_word: d, first_of_call: f, last_of_call: l};
    row.known = known;
    row.typed = '{random_value: v, state_now: st, initial_seed: sd, seed_refused: rf};
    directed_plan.push_back(row);
  endtask

  // Offers one beat, holding it steady until the core takes it, then records
  // what should come back. Valid is only ever lowered during a sender gap.
  task automatic send_item(input in_beat_t beat, input logic known,
                           input out_beat_t typed);
    out_beat_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_beat(beat, predicted);
    awaited_results.push_back(known ? typed : predicted);
  endtask

  // Random traffic. Most of it is well-formed entropy buffers and draws with
  // random content; the rest is seeds, with the awkward ones favoured, and
  // noise beats with arbitrary commands and flags.
  task automatic run_random(input int count);
    int done;
    int pick;
    int len;
    int nbytes;
    in_beat_t b;
    logic [31:0] base;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      b.data_word = $urandom;
      b.first_of_call = 1'($urandom_range(1));
      b.last_of_call = 1'($urandom_range(1));
      if (pick < 25) begin
        b.command = CMD_DRAW31;
        send_item(b, 1'b0, '0);
        done++;
      end else if (pick < 45) begin
        b.command = CMD_DRAW32;
        send_item(b, 1'b0, '0);
        done++;
      end else if (pick < 75) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          b.command = CMD_MIX;
          b.data_word = $urandom;
          b.first_of_call = (k == 0);
          b.last_of_call = (k == len - 1);
          if (b.last_of_call && $urandom_range(2) == 0) begin
            // A short tail word sits right-justified.
            nbytes = $urandom_range(1, 3);
            b.data_word = b.data_word & (32'hffff_ffff >> (8 * (4 - nbytes)));
          end
          if (b.last_of_call && $urandom_range(5) == 0) begin
            // Aim the buffer at a zero remainder so the kept draw comes back.
            base = b.first_of_call ? lehmer_step(lcg_state) : lcg_state;
            b.data_word = base ^ ($urandom_range(1) ? MODULUS : 32'd0);
          end
          send_item(b, 1'b0, '0);
          done++;
          if (k < len - 1 && $urandom_range(9) == 0) begin
            // A draw while the buffer is still open.
            b.command = $urandom_range(1) ? CMD_DRAW32 : CMD_DRAW31;
            b.data_word = $urandom;
            send_item(b, 1'b0, '0);
            done++;
          end
        end
      end else if (pick < 85) begin
        b.command = CMD_SEED;
        case ($urandom_range(7))
          0: b.data_word = 32'd0;
          1: b.data_word = MODULUS;
          2: b.data_word = 32'hffff_fffe;
          3: b.data_word = 32'hffff_ffff;
          4: b.data_word = 32'h7fff_fffe;
          default: ;
        endcase
        send_item(b, 1'b0, '0);
        done++;
      end else begin
        b.command = cmd_t'($urandom_range(3));
        send_item(b, 1'b0, '0);
        done++;
      end
    end
  endtask

  task automatic report_if_differs(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Receiver side. A hold-off order from the main sequence is counted out
  // here; otherwise the stall is drawn at the current idling rate.
  always @(posedge clk) begin
    if (hold_seen != hold_orders) begin
      hold_seen <= hold_orders;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checking: every beat taken from the core must match the oldest
  // prediction still waiting.
  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: result beat with none expected: %h", $time, out_data);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        report_if_differs("random_value", want.random_value, out_data.random_value);
        report_if_differs("state_now", want.state_now, out_data.state_now);
        report_if_differs("initial_seed", {1'b0, want.initial_seed},
                          {1'b0, out_data.initial_seed});
        report_if_differs("seed_refused", {31'd0, want.seed_refused},
                          {31'd0, out_data.seed_refused});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("minimal_standard_prng_31_core: mismatch");
      $finish;
    end
  end

  initial begin
    // Directed list. From reset the state is 1, so the first draw is the
    // multiplier itself; its flags must be ignored.
    add_row(CMD_DRAW31, 32'd0, 1'b1, 1'b1, 1'b1, 32'd16807, 32'd16807, 31'd1, 1'b0);
    // Zero seed, in all three spellings that a 32-bit word allows.
    add_row(CMD_SEED, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 32'd16807, 31'd1, 1'b1);
    add_row(CMD_SEED, 32'h7fff_ffff, 1'b0, 1'b0, 1'b1, 32'd0, 32'd16807, 31'd1, 1'b1);
    add_row(CMD_SEED, 32'hffff_fffe, 1'b1, 1'b1, 1'b1, 32'd0, 32'd16807, 31'd1, 1'b1);
    // All ones reduces to a seed of 1.
    add_row(CMD_SEED, 32'hffff_ffff, 1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 31'd1, 1'b0);
    add_row(CMD_DRAW32, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_SEED, 32'h7fff_fffe, 1'b0, 1'b0, 1'b1,
            32'd0, 32'h7fff_fffe, 31'h7fff_fffe, 1'b0);
    add_row(CMD_DRAW31, 32'd0, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    // One-word buffer that cancels the opening draw: the kept draw returns.
    add_row(CMD_SEED, 32'd5, 1'b0, 1'b0, 1'b1, 32'd0, 32'd5, 31'd5, 1'b0);
    add_row(CMD_MIX, 32'd84035, 1'b1, 1'b1, 1'b1, 32'd0, 32'd84035, 31'd5, 1'b0);
    // Closing word without an opening one restores the older kept draw.
    add_row(CMD_SEED, 32'd7, 1'b0, 1'b0, 1'b1, 32'd0, 32'd7, 31'd7, 1'b0);
    add_row(CMD_MIX, 32'd7, 1'b0, 1'b1, 1'b1, 32'd0, 32'd84035, 31'd7, 1'b0);
    // An open buffer can leave the state at zero, and draws keep it there.
    add_row(CMD_SEED, 32'd3, 1'b0, 1'b0, 1'b1, 32'd0, 32'd3, 31'd3, 1'b0);
    add_row(CMD_MIX, 32'd3, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 31'd3, 1'b0);
    add_row(CMD_DRAW31, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 31'd3, 1'b0);
    add_row(CMD_DRAW32, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 31'd3, 1'b0);
    // Draws from a state of all ones and from exactly the modulus.
    add_row(CMD_MIX, 32'hffff_ffff, 1'b0, 1'b0, 1'b1, 32'd0, 32'hffff_ffff, 31'd3, 1'b0);
    add_row(CMD_DRAW31, 32'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_SEED, 32'd1, 1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 31'd1, 1'b0);
    add_row(CMD_MIX, 32'h7fff_fffe, 1'b0, 1'b0, 1'b1,
            32'd0, 32'h7fff_ffff, 31'd1, 1'b0);
    add_row(CMD_DRAW32, 32'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    // A two-word buffer with a draw inside it and a short tail word.
    add_row(CMD_MIX, 32'h8000_0000, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_DRAW32, 32'd0, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_MIX, 32'h0000_00ff, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_MIX, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0);
    add_row(CMD_DRAW32, 32'h5555_aaaa, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // First phase: the sender idles now and then, the receiver mostly stalls.
    send_idle_pct = 30;
    recv_idle_pct = 67;
    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].stim, directed_plan[i].known, directed_plan[i].typed);
    end
    run_random(360);

    // Second phase: the other way round.
    send_idle_pct = 67;
    recv_idle_pct = 30;
    run_random(380);

    // Last phase: no idling at all, opened by a long receiver hold-off while
    // the sender keeps offering beats.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_orders <= hold_orders + 1;
    run_random(390);

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("minimal_standard_prng_31_core: match");
    end else begin
      $display("minimal_standard_prng_31_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mspr31_pkg.sv
hdl/mspr31_mulfold.sv
hdl/minimal_standard_prng_31_core.sv
verif/testbench.sv
